@@ rtl/core/tsle_pkg.sv @@
// ----------------------------------------------------------------------------
// tsle_pkg
// shared types, codes and helpers of the text screen line editor
// ----------------------------------------------------------------------------
package tsle_pkg;

	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 8;

	localparam logic [7:0] RESET_COLOR = 8'h07;
	localparam logic [7:0] BLANK_CHAR  = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_BACKSP   = 8'h08;

	localparam logic [3:0] OP_WRITE  = 4'd0;
	localparam logic [3:0] OP_INSERT = 4'd1;
	localparam logic [3:0] OP_LEFT   = 4'd2;
	localparam logic [3:0] OP_RIGHT  = 4'd3;
	localparam logic [3:0] OP_SETROW = 4'd4;
	localparam logic [3:0] OP_SETCOL = 4'd5;
	localparam logic [3:0] OP_PUT    = 4'd6;
	localparam logic [3:0] OP_READ   = 4'd7;
	localparam logic [3:0] OP_CLEAR  = 4'd8;

	// memory word: tab mark, occupied mark, attribute, character
	localparam int WORD_W = 18;

	typedef struct packed {
		logic [3:0] opcode;
		logic [7:0] char_code;
		logic [7:0] cell_color;
		logic [7:0] row_value;
		logic [7:0] column_value;
	} req_t;

	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_column;
		logic [10:0] cursor_linear;
		logic [15:0] cell_data;
	} res_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISP, ST_PUT_WR, ST_RD_WAIT, ST_INS_START, ST_INS_WR,
		ST_INS_ADV, ST_NEWLINE, ST_SCROLL_FILL, ST_INS_NEXT, ST_MOVE, ST_FILL,
		ST_SB_RD, ST_SB_CK, ST_BS_FILL, ST_MX_RD, ST_MX_CK, ST_SA_RD, ST_SA_CK,
		ST_DONE
	} state_t;

	// remainder by a small stop distance through a reciprocal multiply,
	// recip is ceil(2^16 / t), exact for v below 512
	function automatic logic [4:0] tab_mod(input logic [8:0] v, input logic [4:0] t,
			input logic [16:0] recip);
		logic [25:0] p;
		logic [8:0]  q;
		logic [13:0] qt;
		p  = 26'(v) * 26'(recip);
		q  = p[24:16];
		qt = 14'(q) * 14'(t);
		return 5'(14'(v) - qt);
	endfunction

endpackage

@@ rtl/core/tsle_ram.sv @@
// ----------------------------------------------------------------------------
// tsle_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module tsle_ram #(
	parameter int DEPTH = 2000,
	parameter int WIDTH = 18,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/core/tsle_engine.sv @@
// ----------------------------------------------------------------------------
// tsle_engine
// sequencer that edits the cell memory by streamed read-modify-write passes
// ----------------------------------------------------------------------------
module tsle_engine #(
	parameter int COLUMNS  = tsle_pkg::COLUMNS_DEF,
	parameter int ROWS     = tsle_pkg::ROWS_DEF,
	parameter int TAB_STOP = tsle_pkg::TAB_STOP_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tsle_pkg::req_t req,
	output logic           idle,
	input  logic [7:0]     text_color,
	output logic           res_valid,
	input  logic           res_ready,
	output tsle_pkg::res_t res
);
	import tsle_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int NW    = $clog2(CELLS + 1);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS + 1);
	localparam logic [16:0] TAB_RECIP = 17'((65536 + TAB_STOP - 1) / TAB_STOP);

	state_t            state_q, state_d, ret_q, ret_d;
	req_t              req_q, req_d;
	logic [RW-1:0]     row_q, row_d;
	logic [CW-1:0]     col_q, col_d;
	logic [15:0]       data_q, data_d;
	logic [AW-1:0]     src_q, src_d, dst_q, dst_d;
	logic [NW-1:0]     cnt_q, cnt_d;
	logic              pend_q, pend_d, up_q, up_d;
	logic [WORD_W-1:0] fill_q, fill_d;
	logic [CW-1:0]     ptr_q, ptr_d, mx_q, mx_d, n_q, n_d;
	logic              first_q, first_d, tabf_q, tabf_d;
	logic [4:0]        rem_q, rem_d;
	logic [7:0]        ins_ch_q, ins_ch_d;

	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [WORD_W-1:0] wr_data, rd_data;

	logic [AW-1:0]     base, req_addr;
	logic              req_in_range;
	logic [4:0]        col_mod, tab_w;
	logic [CW-1:0]     ptr_m1, ptr_p1, mx_v, new_col;
	logic              found;
	logic [WORD_W-1:0] blank_word;

	tsle_ram #(.DEPTH(CELLS), .WIDTH(WORD_W)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign base         = AW'(int'(row_q) * COLUMNS);
	assign req_in_range = (int'(req_q.row_value) < ROWS) && (int'(req_q.column_value) < COLUMNS);
	assign req_addr     = AW'(int'(req_q.row_value) * COLUMNS + int'(req_q.column_value));
	assign col_mod      = tab_mod(9'(col_q), 5'(TAB_STOP), TAB_RECIP);
	assign tab_w        = 5'(TAB_STOP) - col_mod;
	assign ptr_m1       = ptr_q - CW'(1);
	assign ptr_p1       = ptr_q + CW'(1);
	assign blank_word   = {2'b00, text_color, BLANK_CHAR};
	assign found        = rd_data[17] | rd_data[16] | (rd_data[7:0] != BLANK_CHAR);
	assign mx_v         = (int'(ptr_q) < COLUMNS - 1) ? ptr_p1 : CW'(COLUMNS - 1);

	assign res.cursor_row    = 5'(row_q);
	assign res.cursor_column = 7'(col_q);
	assign res.cursor_linear = 11'(int'(row_q) * COLUMNS + int'(col_q));
	assign res.cell_data     = data_q;

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		req_d    = req_q;
		row_d    = row_q;
		col_d    = col_q;
		data_d   = data_q;
		src_d    = src_q;
		dst_d    = dst_q;
		cnt_d    = cnt_q;
		pend_d   = pend_q;
		up_d     = up_q;
		fill_d   = fill_q;
		ptr_d    = ptr_q;
		mx_d     = mx_q;
		n_d      = n_q;
		first_d  = first_q;
		tabf_d   = tabf_q;
		rem_d    = rem_q;
		ins_ch_d = ins_ch_q;
		new_col  = col_q;
		rd_en    = 1'b0;
		rd_addr  = src_q;
		wr_en    = 1'b0;
		wr_addr  = dst_q;
		wr_data  = fill_q;
		idle     = 1'b0;
		res_valid = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					req_d   = req;
					data_d  = '0;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				state_d = ST_DONE;
				unique case (req_q.opcode)
					OP_WRITE: begin
						priority if (req_q.char_code == CH_TAB) begin
							rem_d    = tab_w;
							tabf_d   = (int'(col_q) + int'(tab_w)) < COLUMNS;
							ins_ch_d = BLANK_CHAR;
							state_d  = ST_INS_START;
						end else if (req_q.char_code == CH_NEWLINE) begin
							rem_d   = '0;
							state_d = ST_NEWLINE;
						end else if (req_q.char_code == CH_BACKSP) begin
							if (row_q == '0 && col_q == '0)
								state_d = ST_DONE;
							else if (col_q == '0) begin
								row_d   = row_q - RW'(1);
								ptr_d   = CW'(COLUMNS - 1);
								state_d = ST_MX_RD;
							end else begin
								ptr_d   = col_q;
								first_d = 1'b1;
								state_d = ST_SB_RD;
							end
						end else begin
							rem_d    = 5'd1;
							tabf_d   = 1'b0;
							ins_ch_d = req_q.char_code;
							state_d  = ST_INS_START;
						end
					end
					OP_INSERT: begin
						rem_d    = 5'd1;
						tabf_d   = 1'b0;
						ins_ch_d = req_q.char_code;
						state_d  = ST_INS_START;
					end
					OP_LEFT: begin
						if (col_q != '0) begin
							ptr_d   = col_q;
							first_d = 1'b1;
							state_d = ST_SB_RD;
						end
					end
					OP_RIGHT: begin
						ptr_d   = CW'(COLUMNS - 1);
						state_d = ST_MX_RD;
					end
					OP_SETROW: begin
						row_d = (int'(req_q.row_value) < ROWS) ? RW'(req_q.row_value)
							: RW'(ROWS - 1);
					end
					OP_SETCOL: begin
						col_d = (int'(req_q.column_value) < COLUMNS) ? CW'(req_q.column_value)
							: CW'(COLUMNS - 1);
					end
					OP_PUT: begin
						if (req_in_range) begin
							rd_en   = 1'b1;
							rd_addr = req_addr;
							state_d = ST_PUT_WR;
						end
					end
					OP_READ: begin
						if (req_in_range) begin
							rd_en   = 1'b1;
							rd_addr = req_addr;
							state_d = ST_RD_WAIT;
						end
					end
					OP_CLEAR: begin
						row_d   = '0;
						col_d   = '0;
						dst_d   = '0;
						cnt_d   = NW'(CELLS);
						fill_d  = blank_word;
						ret_d   = ST_DONE;
						state_d = ST_FILL;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_PUT_WR: begin
				// marks stay as they were
				wr_en   = 1'b1;
				wr_addr = req_addr;
				wr_data = {rd_data[17:16], req_q.cell_color, req_q.char_code};
				state_d = ST_DONE;
			end
			ST_RD_WAIT: begin
				data_d  = rd_data[15:0];
				state_d = ST_DONE;
			end
			ST_INS_START: begin
				src_d   = base + AW'(COLUMNS - 2);
				dst_d   = base + AW'(COLUMNS - 1);
				cnt_d   = NW'(COLUMNS - 1 - int'(col_q));
				up_d    = 1'b0;
				pend_d  = 1'b0;
				ret_d   = ST_INS_WR;
				state_d = ST_MOVE;
			end
			ST_INS_WR: begin
				wr_en   = 1'b1;
				wr_addr = base + AW'(col_q);
				wr_data = {tabf_q, 1'b1, text_color, ins_ch_q};
				rem_d   = rem_q - 5'd1;
				state_d = ST_INS_ADV;
			end
			ST_INS_ADV: begin
				if (int'(col_q) == COLUMNS - 1)
					state_d = ST_NEWLINE;
				else begin
					col_d   = col_q + CW'(1);
					state_d = ST_INS_NEXT;
				end
			end
			ST_NEWLINE: begin
				col_d = '0;
				if (int'(row_q) == ROWS - 1) begin
					src_d   = AW'(COLUMNS);
					dst_d   = '0;
					cnt_d   = NW'(CELLS - COLUMNS);
					up_d    = 1'b1;
					pend_d  = 1'b0;
					ret_d   = ST_SCROLL_FILL;
					state_d = ST_MOVE;
				end else begin
					row_d   = row_q + RW'(1);
					state_d = ST_INS_NEXT;
				end
			end
			ST_SCROLL_FILL: begin
				dst_d   = AW'(CELLS - COLUMNS);
				cnt_d   = NW'(COLUMNS);
				fill_d  = blank_word;
				ret_d   = ST_INS_NEXT;
				state_d = ST_FILL;
			end
			ST_INS_NEXT: begin
				state_d = (rem_q != '0) ? ST_INS_START : ST_DONE;
			end
			ST_MOVE: begin
				// read one entry per cycle, write it in the cycle after its read
				rd_addr = src_q;
				wr_addr = dst_q;
				wr_data = rd_data;
				if (cnt_q != '0) begin
					rd_en = 1'b1;
					src_d = up_q ? src_q + AW'(1) : src_q - AW'(1);
					cnt_d = cnt_q - NW'(1);
				end
				if (pend_q) begin
					wr_en = 1'b1;
					dst_d = up_q ? dst_q + AW'(1) : dst_q - AW'(1);
				end
				pend_d = (cnt_q != '0);
				if (cnt_q == '0 && !pend_q)
					state_d = ret_q;
			end
			ST_FILL: begin
				if (cnt_q != '0) begin
					wr_en = 1'b1;
					dst_d = dst_q + AW'(1);
					cnt_d = cnt_q - NW'(1);
				end else
					state_d = ret_q;
			end
			ST_SB_RD: begin
				rd_en   = 1'b1;
				rd_addr = base + AW'(ptr_m1);
				state_d = ST_SB_CK;
			end
			ST_SB_CK: begin
				priority if (rd_data[17] && ptr_m1 != '0
						&& tab_mod(9'(ptr_m1), 5'(TAB_STOP), TAB_RECIP) != '0) begin
					first_d = 1'b0;
					ptr_d   = ptr_m1;
					state_d = ST_SB_RD;
				end else begin
					if (rd_data[17])
						new_col = ptr_m1;
					else if (first_q)
						new_col = col_q - CW'(1);
					else
						new_col = ptr_q;
					col_d = new_col;
					if (req_q.opcode == OP_LEFT)
						state_d = ST_DONE;
					else begin
						// delete the span and pull the rest of the row left
						n_d     = col_q - new_col;
						src_d   = base + AW'(col_q);
						dst_d   = base + AW'(new_col);
						cnt_d   = NW'(COLUMNS - int'(col_q));
						up_d    = 1'b1;
						pend_d  = 1'b0;
						ret_d   = ST_BS_FILL;
						state_d = ST_MOVE;
					end
				end
			end
			ST_BS_FILL: begin
				dst_d   = base + AW'(COLUMNS) - AW'(n_q);
				cnt_d   = NW'(n_q);
				fill_d  = blank_word;
				ret_d   = ST_DONE;
				state_d = ST_FILL;
			end
			ST_MX_RD: begin
				rd_en   = 1'b1;
				rd_addr = base + AW'(ptr_q);
				state_d = ST_MX_CK;
			end
			ST_MX_CK: begin
				if (!found && ptr_q != '0) begin
					ptr_d   = ptr_m1;
					state_d = ST_MX_RD;
				end else begin
					new_col = found ? mx_v : '0;
					state_d = ST_DONE;
					if (req_q.opcode == OP_RIGHT) begin
						if (col_q < new_col) begin
							mx_d    = new_col;
							ptr_d   = col_q;
							first_d = 1'b1;
							state_d = ST_SA_RD;
						end
					end else
						col_d = new_col;
				end
			end
			ST_SA_RD: begin
				rd_en   = 1'b1;
				rd_addr = base + AW'(ptr_q);
				state_d = ST_SA_CK;
			end
			ST_SA_CK: begin
				priority if (rd_data[17] && ptr_p1 < mx_q
						&& tab_mod(9'(ptr_p1), 5'(TAB_STOP), TAB_RECIP) != '0) begin
					first_d = 1'b0;
					ptr_d   = ptr_p1;
					state_d = ST_SA_RD;
				end else begin
					if (rd_data[17])
						col_d = ptr_p1;
					else if (first_q)
						col_d = col_q + CW'(1);
					else
						col_d = ptr_q;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// after reset the whole memory is blanked before the first request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_FILL;
			ret_q    <= ST_IDLE;
			dst_q    <= '0;
			cnt_q    <= NW'(CELLS);
			fill_q   <= {2'b00, RESET_COLOR, BLANK_CHAR};
			row_q    <= '0;
			col_q    <= '0;
			data_q   <= '0;
			pend_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			dst_q    <= dst_d;
			cnt_q    <= cnt_d;
			fill_q   <= fill_d;
			row_q    <= row_d;
			col_q    <= col_d;
			data_q   <= data_d;
			pend_q   <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q    <= req_d;
		src_q    <= src_d;
		up_q     <= up_d;
		ptr_q    <= ptr_d;
		mx_q     <= mx_d;
		n_q      <= n_d;
		first_q  <= first_d;
		tabf_q   <= tabf_d;
		rem_q    <= rem_d;
		ins_ch_q <= ins_ch_d;
	end

endmodule

@@ rtl/core/text_screen_line_editor_core.sv @@
// ----------------------------------------------------------------------------
// text_screen_line_editor_core
// character-cell text screen with an insert-mode line editor
// ----------------------------------------------------------------------------
// Takes one request at a time and returns one result per request. Cell,
// tab mark and occupied mark live together in one memory of ROWS*COLUMNS
// words; inserts, deletes, scrolls and clear are passes over that memory,
// one word per cycle. A tab repeats the insert for each blank up to the next
// tab stop. A write past the bottom row scrolls the screen up a row. After
// reset a blanking pass over all ROWS*COLUMNS words (2000 at 80x25) runs
// before the first request is taken; the text color may be written
// at any idle time and applies to later inserts and blank fill.
// ----------------------------------------------------------------------------
module text_screen_line_editor_core #(
	parameter int COLUMNS  = tsle_pkg::COLUMNS_DEF,
	parameter int ROWS     = tsle_pkg::ROWS_DEF,
	parameter int TAB_STOP = tsle_pkg::TAB_STOP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  logic [7:0]  char_code,
	input  logic [7:0]  cell_color,
	input  logic [7:0]  row_value,
	input  logic [7:0]  column_value,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_column,
	output logic [10:0] cursor_linear,
	output logic [15:0] cell_data,
	// text color register
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);
	import tsle_pkg::*;

	logic       text_color_q;
	logic [7:0] color_q;
	req_t       req;
	res_t       eng_res, res_q;
	logic       start, eng_idle, eng_res_valid, eng_res_ready;
	logic       out_valid_q;

	// request fields bundled for the engine
	assign req.opcode       = opcode;
	assign req.char_code    = char_code;
	assign req.cell_color   = cell_color;
	assign req.row_value    = row_value;
	assign req.column_value = column_value;

	// a new request is taken whenever the engine is idle, even while the
	// previous result still sits in the output register
	assign in_ready = eng_idle;
	assign start    = in_valid & in_ready;

	// engine may hand over its result when the output register is free or being read out
	assign eng_res_ready = !out_valid_q || out_ready;

	tsle_engine #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req),
		.idle       (eng_idle),
		.text_color (color_q),
		.res_valid  (eng_res_valid),
		.res_ready  (eng_res_ready),
		.res        (eng_res)
	);

	// text color register, written without handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q      <= RESET_COLOR;
			text_color_q <= 1'b0;
		end else if (cfg_we) begin
			color_q      <= cfg_wdata;
			text_color_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (eng_res_valid && eng_res_ready)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (eng_res_valid && eng_res_ready)
			res_q <= eng_res;
	end

	assign out_valid     = out_valid_q;
	assign cursor_row    = res_q.cursor_row;
	assign cursor_column = res_q.cursor_column;
	assign cursor_linear = res_q.cursor_linear;
	assign cell_data     = res_q.cell_data;

	// engine leaves idle right after taking a request
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready)
		else $error("engine still idle after request");

	// a handed over result always lands in the output register
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		eng_res_valid && eng_res_ready |=> out_valid)
		else $error("result lost");

	// idle and result pending never overlap
	a_idle_excl: assert property (@(posedge clk) disable iff (!arst_n)
		eng_idle |-> !eng_res_valid)
		else $error("idle with pending result");

	// a color write always loads the written value into the color register
	a_color_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> text_color_q && color_q == $past(cfg_wdata))
		else $error("text color not written");

endmodule
